/* rtl/core/dvi_postamble_parser_macros.svh */
// Assertion helpers for the postamble parser.
`ifndef DVI_POSTAMBLE_PARSER_MACROS_SVH
`define DVI_POSTAMBLE_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset
`define DVIPP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dvipp assertion failed");
// Next-cycle implication, disabled while in reset
`define DVIPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dvipp assertion failed");
`else
`define DVIPP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DVIPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/dvipp_pkg.sv */
package dvipp_pkg;

    // Opcodes seen in the postamble
    localparam logic [7:0] OP_NOP       = 8'd138;
    localparam logic [7:0] OP_FNT_DEF1  = 8'd243;
    localparam logic [7:0] OP_FNT_DEF4  = 8'd246;
    localparam logic [7:0] OP_POST      = 8'd248;
    localparam logic [7:0] OP_POST_POST = 8'd249;

    // Token tags
    localparam logic [3:0] TAG_PREV_PTR   = 4'd0;
    localparam logic [3:0] TAG_STACK      = 4'd6;
    localparam logic [3:0] TAG_PAGES      = 4'd7;
    localparam logic [3:0] TAG_FONT_INDEX = 4'd8;
    localparam logic [3:0] TAG_DESIGN     = 4'd11;
    localparam logic [3:0] TAG_AREA_LEN   = 4'd12;
    localparam logic [3:0] TAG_NAME_LEN   = 4'd13;
    localparam logic [3:0] TAG_NAME_BYTE  = 4'd14;
    localparam logic [3:0] TAG_END        = 4'd15;

    typedef enum logic [2:0] {
        PH_POST,
        PH_HDR,
        PH_FONT_OP,
        PH_FONT,
        PH_NAME,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_POST   = 2'd1,
        ST_BAD_OP    = 2'd2,
        ST_EARLY_END = 2'd3
    } t_status;

    // Parser state carried from byte to byte
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  tag;
        logic [2:0]  bytes_left;
        logic [31:0] acc;
        logic [7:0]  area_len;
        logic [8:0]  name_left;
    } t_pstate;

    // One result token
    typedef struct packed {
        logic [3:0]  tag;
        logic [31:0] value;
        logic        rec_end;
        t_status     status;
    } t_token;

    // Byte count of a field by its tag
    function automatic logic [2:0] field_width(input logic [3:0] tag);
        logic [2:0] w;
        begin
            if (tag == TAG_STACK || tag == TAG_PAGES) w = 3'd2;
            else if (tag == TAG_AREA_LEN || tag == TAG_NAME_LEN) w = 3'd1;
            else w = 3'd4;
            return w;
        end
    endfunction

endpackage

/* rtl/core/dvipp_step.sv */
module dvipp_step
    import dvipp_pkg::*;
(
    input  t_pstate    i_state,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_pstate    o_state,
    output logic       o_emit,
    output t_token     o_token
);

    logic [31:0] n_acc;
    logic [2:0]  n_left;
    logic [8:0]  n_name_left;
    logic [8:0]  n_name_total;

    assign n_acc        = {i_state.acc[23:0], i_byte};
    assign n_left       = i_state.bytes_left - 3'd1;
    assign n_name_left  = i_state.name_left - 9'd1;
    assign n_name_total = {1'b0, i_state.area_len} + {1'b0, n_acc[7:0]};

    // Per-byte state update and token build
    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_token = '{tag: TAG_END, value: 32'd0, rec_end: 1'b0, status: ST_OK};

        if (i_state.phase != PH_STOP && i_eos) begin
            o_state.phase  = PH_STOP;
            o_emit         = 1'b1;
            o_token.status = ST_EARLY_END;
        end else begin
            unique case (i_state.phase)
                PH_STOP: ;
                PH_POST: begin
                    if (i_byte != OP_POST) begin
                        o_state.phase  = PH_STOP;
                        o_emit         = 1'b1;
                        o_token.status = ST_NO_POST;
                    end else begin
                        o_state.phase      = PH_HDR;
                        o_state.tag        = TAG_PREV_PTR;
                        o_state.bytes_left = field_width(TAG_PREV_PTR);
                        o_state.acc        = 32'd0;
                    end
                end
                PH_FONT_OP: begin
                    if (i_byte == OP_NOP) begin
                        o_emit = 1'b0;
                    end else if (i_byte >= OP_FNT_DEF1 && i_byte <= OP_FNT_DEF4) begin
                        o_state.phase      = PH_FONT;
                        o_state.tag        = TAG_FONT_INDEX;
                        o_state.bytes_left = 3'(i_byte - OP_FNT_DEF1 + 8'd1);
                        o_state.acc        = 32'd0;
                    end else begin
                        o_state.phase  = PH_STOP;
                        o_emit         = 1'b1;
                        o_token.status = (i_byte == OP_POST_POST) ? ST_OK : ST_BAD_OP;
                    end
                end
                PH_NAME: begin
                    o_state.name_left = n_name_left;
                    o_emit            = 1'b1;
                    o_token.tag       = TAG_NAME_BYTE;
                    o_token.value     = {24'd0, i_byte};
                    if (n_name_left == 9'd0) begin
                        o_token.rec_end = 1'b1;
                        o_state.phase   = PH_FONT_OP;
                    end
                end
                PH_HDR, PH_FONT: begin
                    o_state.acc        = n_acc;
                    o_state.bytes_left = n_left;
                    if (n_left == 3'd0) begin
                        o_emit        = 1'b1;
                        o_token.tag   = i_state.tag;
                        o_token.value = n_acc;
                        if (i_state.tag == TAG_PAGES) begin
                            // header done
                            o_token.rec_end = 1'b1;
                            o_state.phase   = PH_FONT_OP;
                        end else if (i_state.tag == TAG_NAME_LEN) begin
                            o_state.name_left = n_name_total;
                            if (n_name_total == 9'd0) begin
                                o_token.rec_end = 1'b1;
                                o_state.phase   = PH_FONT_OP;
                            end else begin
                                o_state.phase = PH_NAME;
                            end
                        end else begin
                            // move on to the next fixed field
                            if (i_state.tag == TAG_AREA_LEN) begin
                                o_state.area_len = n_acc[7:0];
                            end
                            o_state.tag        = i_state.tag + 4'd1;
                            o_state.bytes_left = field_width(i_state.tag + 4'd1);
                            o_state.acc        = 32'd0;
                        end
                    end
                end
                default: begin
                    o_state.phase = PH_STOP;
                end
            endcase
        end
    end

endmodule

/* rtl/core/dvi_postamble_parser.sv */
// DVI postamble parser.
// Input stream: one postamble byte per transfer in s_tdata[7:0], starting at
// the post opcode; s_tlast high marks end of file and carries no byte.
// Output stream: one token per completed field. m_tdata holds the value,
// m_tuser the tag (bits 3:0) and status (bits 5:4), m_tlast marks the last
// token of the header or of a font definition. Tag 15 ends the stream: status
// 0 after post_post, otherwise the error code.
// Pipeline: a byte goes into the input register, and its token, if any, is
// then held in the result register. Throughput: one byte per cycle while the
// receiver takes tokens; the per-byte state update is combinational.
// The post and font-definition opcodes, nops and the leading bytes of
// multi-byte fields produce no token.
// Reset (synchronous, active low) empties both registers and returns the
// parser to waiting for the post opcode. After tag 15 the parser drops all
// further bytes until reset.
// When the receiver stalls, the result register holds; the input register
// keeps one more byte and s_tready falls until the token is taken.
`include "dvi_postamble_parser_macros.svh"

module dvi_postamble_parser
    import dvipp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] field_value
    output logic [5:0]  o_m_tuser,   // [3:0] field_tag, [5:4] status
    output logic        o_m_tlast    // record_end
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    t_pstate    r_state;
    logic       r_out_valid;
    t_token     r_out_tok;

    t_pstate    n_state;
    logic       n_emit;
    t_token     n_token;
    logic       advance;

    // Result register free or being drained
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    dvipp_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_state (n_state),
        .o_emit  (n_emit),
        .o_token (n_token)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_eos  <= i_s_tlast;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_POST, tag: TAG_PREV_PTR, bytes_left: 3'd0,
                         acc: 32'd0, area_len: 8'd0, name_left: 9'd0};
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && n_emit) begin
            r_out_tok <= n_token;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tok.value;
    assign o_m_tuser  = {r_out_tok.status, r_out_tok.tag};
    assign o_m_tlast  = r_out_tok.rec_end;

    // Checks
    `DVIPP_ASSERT_IMPL(a_status_on_end, i_clk, i_rst_n,
        r_out_valid && r_out_tok.status != ST_OK, r_out_tok.tag == TAG_END)
    `DVIPP_ASSERT_IMPL(a_rec_end_tag, i_clk, i_rst_n,
        r_out_valid && r_out_tok.rec_end,
        r_out_tok.tag == TAG_PAGES || r_out_tok.tag == TAG_NAME_LEN ||
        r_out_tok.tag == TAG_NAME_BYTE)
    `DVIPP_ASSERT_NEXT(a_stop_sticks, i_clk, i_rst_n,
        r_state.phase == PH_STOP, r_state.phase == PH_STOP)
    `DVIPP_ASSERT_NEXT(a_end_stops, i_clk, i_rst_n,
        r_in_valid && advance && n_emit && n_token.tag == TAG_END,
        r_state.phase == PH_STOP)

endmodule
